### rtl/vafp_pkg.sv
// Shared constants for the velocity azimuth and flight-path core.
// Holds field widths, the angle constants and the CORDIC arctangent table.
// No dependencies.
package vafp_pkg;

  localparam int VEL_W     = 32;
  localparam int HZ_W      = 31;
  localparam int HEAD_W    = 31;
  localparam int CLIMB_W   = 30;
  localparam int ANG_W     = 32;
  localparam int CORDIC_W  = 36;
  localparam int CORDIC_STAGES_DEF = 28;

  localparam logic signed [ANG_W-1:0] ANG_PI   = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_PI_2 = 32'sd421657428;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

  // atan(2^-i) in Q4.28 radians.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [0:31] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879,   32'sd4193963,   32'sd2097109,  32'sd1048571,  32'sd524287,
    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,    32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,       32'sd16,
    32'sd8,         32'sd4,         32'sd2,        32'sd1,        32'sd0,
    32'sd0,         32'sd0
  };

endpackage

### rtl/vafp_rotate.sv
// Matrix-vector rotation into the local frame: nine products, then row sums.
// Two register stages; rounds Q18.46 to Q16.16 and saturates. Uses vafp_pkg.
module vafp_rotate import vafp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [8:0][VEL_W-1:0] mat,
  input  logic [2:0][VEL_W-1:0] vec,
  output logic                  out_valid,
  output logic [2:0][VEL_W-1:0] loc
);

  logic [8:0][63:0]      prod_nxt, prod_r;
  logic [2:0][VEL_W-1:0] loc_nxt, loc_r;
  logic                  v1_r, v2_r;
  logic signed [65:0]    acc [0:2];
  logic signed [65:0]    shf [0:2];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod_nxt[i] = $signed({{32{mat[i][31]}}, mat[i]}) *
                    $signed({{32{vec[i%3][31]}}, vec[i%3]});
    end
  end

  // Round half up at the Q16.16 point, then clip to 32 bits.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = $signed({{2{prod_r[3*r][63]}}, prod_r[3*r]}) +
               $signed({{2{prod_r[3*r+1][63]}}, prod_r[3*r+1]}) +
               $signed({{2{prod_r[3*r+2][63]}}, prod_r[3*r+2]}) +
               (66'sd1 <<< 29);
      shf[r] = acc[r] >>> 30;
      if (shf[r] > 66'sd2147483647) begin
        loc_nxt[r] = VEL_MAX;
      end else if (shf[r] < -66'sd2147483648) begin
        loc_nxt[r] = VEL_MIN;
      end else begin
        loc_nxt[r] = shf[r][VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      loc_r  <= loc_nxt;
    end
  end

  assign out_valid = v2_r;
  assign loc       = loc_r;

endmodule

### rtl/vafp_sqrt.sv
// Pipelined horizontal speed: squares, sum, one root bit per stage, rounding.
// Carries a sideband word alongside the data. Uses vafp_pkg.
module vafp_sqrt import vafp_pkg::*; #(
  parameter int SIDE_W = 96
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VEL_W-1:0]  north,
  input  logic [VEL_W-1:0]  east,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [HZ_W-1:0]   hz,
  output logic [SIDE_W-1:0] side_out
);

  localparam int ROOT_W = 32;

  logic [63:0]       sqn_full, sqe_full;
  logic [62:0]       sqn_r, sqe_r;
  logic              va_r;
  logic [SIDE_W-1:0] sidea_r;

  logic [ROOT_W-1:0] q_r    [0:ROOT_W];
  logic [63:0]       rem_r  [0:ROOT_W];
  logic              v_r    [0:ROOT_W];
  logic [SIDE_W-1:0] side_r [0:ROOT_W];

  logic [ROOT_W:0]   rnd;
  logic [HZ_W-1:0]   hz_r;
  logic              vf_r;
  logic [SIDE_W-1:0] sidef_r;

  assign sqn_full = $signed({{32{north[31]}}, north}) * $signed({{32{north[31]}}, north});
  assign sqe_full = $signed({{32{east[31]}}, east}) * $signed({{32{east[31]}}, east});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqn_r     <= sqn_full[62:0];
      sqe_r     <= sqe_full[62:0];
      sidea_r   <= side_in;
      rem_r[0]  <= {1'b0, sqn_r} + {1'b0, sqe_r};
      q_r[0]    <= '0;
      side_r[0] <= sidea_r;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int I = ROOT_W - 1 - k;
    logic [65:0] trial;
    assign trial = (66'(q_r[k]) << (I + 1)) + (66'd1 << (2 * I));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        if ({2'b00, rem_r[k]} >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial[63:0];
          q_r[k+1]   <= q_r[k] | (ROOT_W'(1) << I);
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  // Round to nearest: the remainder above the floor root decides.
  assign rnd = {1'b0, q_r[ROOT_W]} + (ROOT_W+1)'(rem_r[ROOT_W] > 64'(q_r[ROOT_W]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidef_r <= side_r[ROOT_W];
      hz_r    <= (rnd[ROOT_W:HZ_W] != '0) ? '1 : rnd[HZ_W-1:0];
    end
  end

  assign out_valid = vf_r;
  assign hz        = hz_r;
  assign side_out  = sidef_r;

endmodule

### rtl/vafp_cordic.sv
// Vectoring CORDIC for atan2(y,x): half-plane turn, one rotation per stage, clamp.
// Carries a sideband word alongside the data. Uses vafp_pkg.
module vafp_cordic import vafp_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 96
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VEL_W-1:0]  x_in,
  input  logic [VEL_W-1:0]  y_in,
  input  logic [ANG_W-1:0]  lim,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [ANG_W-1:0]  angle,
  output logic [SIDE_W-1:0] side_out
);

  logic signed [CORDIC_W-1:0] xe, ye, x0, y0;
  logic signed [ANG_W-1:0]    z0;

  logic signed [CORDIC_W-1:0] x_r    [0:STAGES];
  logic signed [CORDIC_W-1:0] y_r    [0:STAGES];
  logic signed [ANG_W-1:0]    z_r    [0:STAGES];
  logic                       zf_r   [0:STAGES];
  logic                       v_r    [0:STAGES];
  logic [SIDE_W-1:0]          side_r [0:STAGES];

  logic signed [ANG_W-1:0]    zl, lim_s, ang_nxt;
  logic [ANG_W-1:0]           ang_r;
  logic                       vf_r;
  logic [SIDE_W-1:0]          sidef_r;

  assign xe = CORDIC_W'($signed(x_in));
  assign ye = CORDIC_W'($signed(y_in));

  // A vector in the left half plane is turned by pi first.
  always_comb begin
    if (x_in[VEL_W-1]) begin
      x0 = -xe;
      y0 = -ye;
      z0 = y_in[VEL_W-1] ? -ANG_PI : ANG_PI;
    end else begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zf_r[0]   <= (x_in == '0) && (y_in == '0);
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int S = k % 32;
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_r[k] >>> S;
    assign ys = y_r[k] >>> S;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[k+1]   <= zf_r[k];
        side_r[k+1] <= side_r[k];
        if (!y_r[k][CORDIC_W-1]) begin
          x_r[k+1] <= x_r[k] + ys;
          y_r[k+1] <= y_r[k] - xs;
          z_r[k+1] <= z_r[k] + ATAN_TAB[S];
        end else begin
          x_r[k+1] <= x_r[k] - ys;
          y_r[k+1] <= y_r[k] + xs;
          z_r[k+1] <= z_r[k] - ATAN_TAB[S];
        end
      end
    end
  end

  assign zl    = z_r[STAGES];
  assign lim_s = $signed(lim);

  always_comb begin
    if (zf_r[STAGES]) begin
      ang_nxt = '0;
    end else if (zl > lim_s) begin
      ang_nxt = lim_s;
    end else if (zl < -lim_s) begin
      ang_nxt = -lim_s;
    end else begin
      ang_nxt = zl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r   <= ang_nxt;
      sidef_r <= side_r[STAGES];
    end
  end

  assign out_valid = vf_r;
  assign angle     = ang_r;
  assign side_out  = sidef_r;

endmodule

### rtl/velocity_azimuth_flight_path_core.sv
// Top level of the velocity azimuth and flight-path core.
// Instantiates vafp_rotate, vafp_sqrt and two vafp_cordic; uses vafp_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    nine Q2.30 matrix terms, Q16.16 velocity
//   out_     output     out_valid / out_ready  local velocity, speed, two angles, rate
//
// One transfer can enter every cycle while the output register is free or being taken; the path runs
// through the two rotation stages, the 35-stage root pipeline, the CORDIC chain and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// The whole pipeline holds while a result waits untaken, so a stall loses nothing.
module velocity_azimuth_flight_path_core import vafp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VEL_W-1:0]          in_rot_r0c0,
  input  logic [VEL_W-1:0]          in_rot_r0c1,
  input  logic [VEL_W-1:0]          in_rot_r0c2,
  input  logic [VEL_W-1:0]          in_rot_r1c0,
  input  logic [VEL_W-1:0]          in_rot_r1c1,
  input  logic [VEL_W-1:0]          in_rot_r1c2,
  input  logic [VEL_W-1:0]          in_rot_r2c0,
  input  logic [VEL_W-1:0]          in_rot_r2c1,
  input  logic [VEL_W-1:0]          in_rot_r2c2,
  input  logic [VEL_W-1:0]          in_vel_x,
  input  logic [VEL_W-1:0]          in_vel_y,
  input  logic [VEL_W-1:0]          in_vel_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VEL_W-1:0]   out_north_vel,
  output logic signed [VEL_W-1:0]   out_east_vel,
  output logic signed [VEL_W-1:0]   out_down_vel,
  output logic [HZ_W-1:0]           out_horiz_speed,
  output logic signed [HEAD_W-1:0]  out_heading_angle,
  output logic signed [CLIMB_W-1:0] out_climb_angle,
  output logic signed [VEL_W-1:0]   out_climb_rate
);

  localparam int LOC_W  = 3 * VEL_W;
  localparam int CLS_W  = HZ_W + VEL_W;

  // Every stage moves together whenever the output register is free or being taken.
  logic adv;

  logic [8:0][VEL_W-1:0] mat;
  logic [2:0][VEL_W-1:0] vec, loc;
  logic                  rot_valid;

  logic                  sq_valid;
  logic [HZ_W-1:0]       sq_hz;
  logic [LOC_W-1:0]      sq_side;
  logic [VEL_W-1:0]      sq_down, climb_rate;

  logic                  hd_valid, cl_valid;
  logic [ANG_W-1:0]      hd_angle, cl_angle;
  logic [LOC_W-1:0]      hd_side;
  logic [CLS_W-1:0]      cl_side;

  logic                  out_valid_r;
  logic [VEL_W-1:0]      north_r, east_r, down_r, rate_r;
  logic [HZ_W-1:0]       hz_r;
  logic [HEAD_W-1:0]     head_r;
  logic [CLIMB_W-1:0]    climb_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign mat = {in_rot_r2c2, in_rot_r2c1, in_rot_r2c0,
                in_rot_r1c2, in_rot_r1c1, in_rot_r1c0,
                in_rot_r0c2, in_rot_r0c1, in_rot_r0c0};
  assign vec = {in_vel_z, in_vel_y, in_vel_x};

  vafp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .mat       (mat),
    .vec       (vec),
    .out_valid (rot_valid),
    .loc       (loc)
  );

  // The local components ride along the root pipeline for the heading angle.
  vafp_sqrt #(
    .SIDE_W (LOC_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (rot_valid),
    .north     (loc[0]),
    .east      (loc[1]),
    .side_in   (loc),
    .out_valid (sq_valid),
    .hz        (sq_hz),
    .side_out  (sq_side)
  );

  // Altitude rate is the negated down component; the most negative value clips.
  assign sq_down    = sq_side[3*VEL_W-1:2*VEL_W];
  assign climb_rate = (sq_down == VEL_MIN) ? VEL_MAX : -sq_down;

  vafp_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (LOC_W)
  ) u_heading (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .x_in      (sq_side[VEL_W-1:0]),
    .y_in      (sq_side[2*VEL_W-1:VEL_W]),
    .lim       (ANG_PI),
    .side_in   (sq_side),
    .out_valid (hd_valid),
    .angle     (hd_angle),
    .side_out  (hd_side)
  );

  vafp_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (CLS_W)
  ) u_climb (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .x_in      ({1'b0, sq_hz}),
    .y_in      (climb_rate),
    .lim       (ANG_PI_2),
    .side_in   ({sq_hz, climb_rate}),
    .out_valid (cl_valid),
    .angle     (cl_angle),
    .side_out  (cl_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= hd_valid && cl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      north_r <= hd_side[VEL_W-1:0];
      east_r  <= hd_side[2*VEL_W-1:VEL_W];
      down_r  <= hd_side[3*VEL_W-1:2*VEL_W];
      hz_r    <= cl_side[CLS_W-1:VEL_W];
      rate_r  <= cl_side[VEL_W-1:0];
      head_r  <= hd_angle[HEAD_W-1:0];
      climb_r <= cl_angle[CLIMB_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_north_vel     = north_r;
  assign out_east_vel      = east_r;
  assign out_down_vel      = down_r;
  assign out_horiz_speed   = hz_r;
  assign out_heading_angle = head_r;
  assign out_climb_angle   = climb_r;
  assign out_climb_rate    = rate_r;

`ifndef ASSERT_OFF
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_angle <= 31'sd843314857) &&
                  (out_heading_angle >= -31'sd843314857))
    else $error("heading angle beyond pi");

  a_climb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_climb_angle <= 30'sd421657428) &&
                  (out_climb_angle >= -30'sd421657428))
    else $error("climb angle beyond pi/2");

  a_rate_matches_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_climb_rate == -out_down_vel) ||
                  ((out_down_vel == VEL_MIN) && (out_climb_rate == VEL_MAX)))
    else $error("climb rate does not match down velocity");

  a_zero_horizontal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_north_vel == '0) && (out_east_vel == '0) |->
      (out_horiz_speed == '0) && (out_heading_angle == '0))
    else $error("zero horizontal velocity gave nonzero speed or heading");
`endif

endmodule
